### rtl/fspd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fspd_pkg
// Shared types and constants of the Floyd-Steinberg palette dither.
// ----------------------------------------------------------------------------
package fspd_pkg;

  // channel values and errors in 1/16 units
  localparam int ERR_W   = 13;
  localparam int VAL_W   = 12;
  localparam int SHARE_W = 14;
  localparam int ENT_W   = 3 * ERR_W;

  // configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_PALETTE_COUNT = 2'd2;

  localparam logic [12:0] IMAGE_WIDTH_RST   = 13'd640;
  localparam logic [15:0] IMAGE_HEIGHT_RST  = 16'd480;
  localparam logic [4:0]  PALETTE_COUNT_RST = 5'd16;

  // error distribution steps, each a read-modify-write on the line buffers
  typedef enum logic [1:0] {
    OP_RIGHT       = 2'd0,  // this row x+1 (7/16), next row x-1 (3/16)
    OP_BELOW       = 2'd1,  // next row x (5/16)
    OP_BELOW_RIGHT = 2'd2   // next row x+1 (1/16)
  } op_t;

  typedef struct packed {
    logic pal_wr;
    logic cap_pix;
    logic rd_cur;
    logic ld_val;
    logic srch_step;
    logic ld_err;
    logic rmw_rd;
    logic rmw_wr;
    op_t  op;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic srch_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

### rtl/fspd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fspd_ctrl
// Sequencer: accept, error fetch, palette search, error spreading, result.
// ----------------------------------------------------------------------------
module fspd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  fspd_pkg::status_t  status,
  output fspd_pkg::cmd_t     cmd
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RDCUR = 9'b000000010,
    ST_ADDV  = 9'b000000100,
    ST_SRCH  = 9'b000001000,
    ST_DRAIN = 9'b000010000,
    ST_ERR   = 9'b000100000,
    ST_RMWRD = 9'b001000000,
    ST_RMWWR = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_t;

  state_t          state, state_next;
  fspd_pkg::op_t   op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= fspd_pkg::OP_RIGHT;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (func) begin
            cmd.pal_wr = 1'b1;
          end else begin
            cmd.cap_pix = 1'b1;
            state_next  = ST_RDCUR;
          end
        end
      end
      ST_RDCUR: begin
        cmd.rd_cur = 1'b1;
        state_next = ST_ADDV;
      end
      ST_ADDV: begin
        cmd.ld_val = 1'b1;
        state_next = ST_SRCH;
      end
      ST_SRCH: begin
        cmd.srch_step = 1'b1;
        if (status.srch_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_ERR;
      end
      ST_ERR: begin
        cmd.ld_err = 1'b1;
        op_next    = fspd_pkg::OP_RIGHT;
        state_next = ST_RMWRD;
      end
      ST_RMWRD: begin
        cmd.rmw_rd = 1'b1;
        state_next = ST_RMWWR;
      end
      ST_RMWWR: begin
        cmd.rmw_wr = 1'b1;
        unique case (op)
          fspd_pkg::OP_RIGHT: begin
            op_next    = fspd_pkg::OP_BELOW;
            state_next = ST_RMWRD;
          end
          fspd_pkg::OP_BELOW: begin
            op_next    = fspd_pkg::OP_BELOW_RIGHT;
            state_next = ST_RMWRD;
          end
          default: begin
            state_next = ST_FIN;
          end
        endcase
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/fspd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fspd_datapath
// Palette, two line buffers of errors, nearest-entry search, result register.
// ----------------------------------------------------------------------------
module fspd_datapath #(
  parameter int MAX_LINE_WIDTH = 4096,
  parameter int PALETTE_DEPTH  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  fspd_pkg::cmd_t     cmd,
  output fspd_pkg::status_t  status,
  input  logic [12:0]        image_width,
  input  logic [15:0]        image_height,
  input  logic [4:0]         palette_count,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic [3:0]         entry_slot,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         chosen_index,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic               frame_end
);

  localparam int AW = $clog2(MAX_LINE_WIDTH);
  localparam int HW = $clog2(MAX_LINE_WIDTH + 1);
  localparam int IW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(PALETTE_DEPTH + 1);
  localparam int EW = fspd_pkg::ERR_W;
  localparam int VW = fspd_pkg::VAL_W;
  localparam int SW = fspd_pkg::SHARE_W;
  localparam int NW = fspd_pkg::ENT_W;

  function automatic logic signed [EW-1:0] sat_add(input logic signed [EW-1:0] e,
                                                   input logic signed [SW-1:0] s);
    logic signed [SW:0] t;
    t = {{2{e[EW-1]}}, e} + {s[SW-1], s};
    if (t > 15'sd4095) return 13'sd4095;
    if (t < -15'sd4096) return -13'sd4096;
    return t[EW-1:0];
  endfunction

  // ---------------- palette
  logic [23:0] pal [PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.pal_wr && (32'(entry_slot) < PALETTE_DEPTH)) begin
      pal[IW'(entry_slot)] <= {red, green, blue};
    end
  end

  // ---------------- effective sizes and position
  logic [31:0]   w32, n32;
  logic [16:0]   h1;
  logic [AW-1:0] col_cnt, x;
  logic [15:0]   row_cnt;
  logic          bank;
  logic [HW-1:0] hw0, hw1, hw_cur, hw_nxt;
  logic          has_right, last_col, last_row;
  logic [CW-1:0] n_eff;

  always_comb begin
    w32 = (image_width == 13'd0) ? 32'd1 : 32'(image_width);
    if (w32 > MAX_LINE_WIDTH) w32 = MAX_LINE_WIDTH;
    n32 = (palette_count == 5'd0) ? 32'd1 : 32'(palette_count);
    if (n32 > PALETTE_DEPTH) n32 = PALETTE_DEPTH;
    n_eff = CW'(n32);
    h1 = (image_height == 16'd0) ? 17'd1 : {1'b0, image_height};
    x  = (32'(col_cnt) >= w32) ? AW'(w32 - 32'd1) : col_cnt;
    has_right = (32'(x) + 32'd1) < w32;
    last_col  = !has_right;
    last_row  = {1'b0, row_cnt} >= (h1 - 17'd1);
    hw_cur = bank ? hw1 : hw0;
    hw_nxt = bank ? hw0 : hw1;
  end

  // ---------------- line buffer ports
  logic [AW-1:0] cur_addr, nxt_addr;
  logic          cur_rd, cur_wr, nxt_rd, nxt_wr;
  logic [NW-1:0] cur_wdata, nxt_wdata, cur_old, nxt_old, rq0, rq1;
  logic [AW-1:0] b0_addr, b1_addr;
  logic          b0_rd, b1_rd, b0_wr, b1_wr;
  logic [NW-1:0] b0_wdata, b1_wdata;
  logic [NW-1:0] mem0 [MAX_LINE_WIDTH];
  logic [NW-1:0] mem1 [MAX_LINE_WIDTH];

  always_comb begin
    cur_rd   = cmd.rd_cur || (cmd.rmw_rd && cmd.op == fspd_pkg::OP_RIGHT);
    cur_wr   = cmd.ld_val || (cmd.rmw_wr && cmd.op == fspd_pkg::OP_RIGHT && has_right);
    cur_addr = (cmd.rd_cur || cmd.ld_val) ? x : x + AW'(1);
    nxt_rd   = cmd.rmw_rd;
    unique case (cmd.op)
      fspd_pkg::OP_RIGHT: begin
        nxt_addr = x - AW'(1);
        nxt_wr   = cmd.rmw_wr && (x != '0);
      end
      fspd_pkg::OP_BELOW: begin
        nxt_addr = x;
        nxt_wr   = cmd.rmw_wr;
      end
      default: begin
        nxt_addr = x + AW'(1);
        nxt_wr   = cmd.rmw_wr && has_right;
      end
    endcase
    b0_addr  = bank ? nxt_addr : cur_addr;
    b0_rd    = bank ? nxt_rd : cur_rd;
    b0_wr    = bank ? nxt_wr : cur_wr;
    b0_wdata = bank ? nxt_wdata : cur_wdata;
    b1_addr  = bank ? cur_addr : nxt_addr;
    b1_rd    = bank ? cur_rd : nxt_rd;
    b1_wr    = bank ? cur_wr : nxt_wr;
    b1_wdata = bank ? cur_wdata : nxt_wdata;
  end

  always_ff @(posedge clk) begin
    if (b0_wr) mem0[b0_addr] <= b0_wdata;
    if (b0_rd) rq0 <= mem0[b0_addr];
  end

  always_ff @(posedge clk) begin
    if (b1_wr) mem1[b1_addr] <= b1_wdata;
    if (b1_rd) rq1 <= mem1[b1_addr];
  end

  // entries at or past the fill count were cleared since last written
  always_comb begin
    cur_old = (HW'(cur_addr) < hw_cur) ? (bank ? rq1 : rq0) : '0;
    nxt_old = (HW'(nxt_addr) < hw_nxt) ? (bank ? rq0 : rq1) : '0;
  end

  // ---------------- pixel, clamped values, shares
  logic [7:0]               pix [3];
  logic [VW-1:0]            val [3];
  logic signed [SW-1:0]     s7 [3], s5 [3], s3 [3], s1 [3];
  logic signed [SW-1:0]     sh_nxt [3];
  logic signed [EW-1:0]     cur_e [3], nxt_e [3];
  logic signed [SW:0]       vsum [3];
  logic [VW-1:0]            val_new [3];
  logic [23:0]              best_rgb;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cur_e[c] = cur_old[NW-1-EW*c -: EW];
      nxt_e[c] = nxt_old[NW-1-EW*c -: EW];
      vsum[c]  = $signed({3'b000, pix[c], 4'b0000}) + {{2{cur_e[c][EW-1]}}, cur_e[c]};
      if (vsum[c] < 0) val_new[c] = '0;
      else if (vsum[c] > 15'sd4080) val_new[c] = 12'd4080;
      else val_new[c] = vsum[c][VW-1:0];
      if (last_row) begin
        sh_nxt[c] = '0;
      end else begin
        unique case (cmd.op)
          fspd_pkg::OP_RIGHT: sh_nxt[c] = s3[c];
          fspd_pkg::OP_BELOW: sh_nxt[c] = s5[c];
          default:            sh_nxt[c] = s1[c];
        endcase
      end
      nxt_wdata[NW-1-EW*c -: EW] = sat_add(nxt_e[c], sh_nxt[c]);
      cur_wdata[NW-1-EW*c -: EW] = cmd.ld_val ? cur_e[c] : sat_add(cur_e[c], s7[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_pix) begin
      pix[0] <= red;
      pix[1] <= green;
      pix[2] <= blue;
    end
    if (cmd.ld_val) begin
      for (int c = 0; c < 3; c++) val[c] <= val_new[c];
    end
  end

  // shares are floor(e * k / 16): arithmetic shift floors
  logic signed [SW-1:0] e_q [3];
  logic signed [16:0]   e_x [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      e_q[c] = $signed({2'b00, val[c]}) - $signed({2'b00, best_rgb[23-8*c -: 8], 4'b0000});
      e_x[c] = {{3{e_q[c][SW-1]}}, e_q[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_err) begin
      for (int c = 0; c < 3; c++) begin
        s7[c] <= SW'((e_x[c] * 17'sd7) >>> 4);
        s5[c] <= SW'((e_x[c] * 17'sd5) >>> 4);
        s3[c] <= SW'((e_x[c] * 17'sd3) >>> 4);
        s1[c] <= SW'(e_x[c] >>> 4);
      end
    end
  end

  // ---------------- search: squares registered, then sum and compare
  logic [IW-1:0]        srch_idx, s1_idx, best_idx;
  logic                 s1_valid;
  logic [23:0]          s1_rgb, ent;
  logic [23:0]          sq [3], sq_new [3];
  logic signed [EW-1:0] dr [3];
  logic signed [25:0]   sqf [3];
  logic [25:0]          sq_sum, best_d;

  always_comb begin
    ent = pal[srch_idx];
    for (int c = 0; c < 3; c++) begin
      dr[c]     = $signed({1'b0, val[c]}) - $signed({1'b0, ent[23-8*c -: 8], 4'b0000});
      sqf[c]    = 26'(dr[c]) * 26'(dr[c]);
      sq_new[c] = sqf[c][23:0];
    end
    sq_sum = 26'(sq[0]) + 26'(sq[1]) + 26'(sq[2]);
    status.srch_last = (CW'(srch_idx) + CW'(1)) == n_eff;
    status.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.srch_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_val) begin
      srch_idx <= '0;
    end else if (cmd.srch_step) begin
      srch_idx <= srch_idx + IW'(1);
    end
    if (cmd.srch_step) begin
      s1_idx <= srch_idx;
      s1_rgb <= ent;
      for (int c = 0; c < 3; c++) sq[c] <= sq_new[c];
    end
    // strict less-than keeps the lowest index on a tie
    if (s1_valid && ((s1_idx == '0) || (sq_sum < best_d))) begin
      best_d   <= sq_sum;
      best_idx <= s1_idx;
      best_rgb <= s1_rgb;
    end
  end

  // ---------------- position, fill counts, result register
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt   <= '0;
      row_cnt   <= '0;
      bank      <= 1'b0;
      hw0       <= '0;
      hw1       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (b0_wr && (HW'(b0_addr) + HW'(1) > hw0)) hw0 <= HW'(b0_addr) + HW'(1);
      if (b1_wr && (HW'(b1_addr) + HW'(1) > hw1)) hw1 <= HW'(b1_addr) + HW'(1);
      if (cmd.fin) begin
        out_valid <= 1'b1;
        if (last_col) begin
          col_cnt <= '0;
          if (last_row) begin
            hw0     <= '0;
            hw1     <= '0;
            row_cnt <= '0;
          end else begin
            // this row's buffer becomes the empty next row
            if (bank) hw1 <= '0;
            else hw0 <= '0;
            bank    <= !bank;
            row_cnt <= row_cnt + 16'd1;
          end
        end else begin
          col_cnt <= x + AW'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      chosen_index <= 4'(best_idx);
      out_red      <= best_rgb[23:16];
      out_green    <= best_rgb[15:8];
      out_blue     <= best_rgb[7:0];
      frame_end    <= last_col && last_row;
    end
  end

endmodule
`default_nettype wire

### rtl/floyd_steinberg_palette_dither.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// floyd_steinberg_palette_dither
// Floyd-Steinberg error diffusion of RGB pixels onto a palette of up to
// PALETTE_DEPTH entries, with an APB register port.
// ----------------------------------------------------------------------------
//  channel  | handshake          | transaction
//  ---------+--------------------+------------------------------------------
//  input    | in_valid/in_ready  | pixel (func 0) or palette write (func 1)
//  output   | out_valid/out_ready| chosen index, entry color, frame_end
//  config   | psel/penable/pwrite| image_width, image_height, palette_count
//
//  A palette write leaves the block ready again. A pixel runs error read,
//  value load, search over the n searched entries, drain, error load, three
//  read-modify-write pairs on the single-port line buffers and the result
//  step before the next accept; search compares one palette entry per cycle.
//  A result waiting at the output stalls only the next pixel's last cycle.
//  Reset is synchronous; the line buffers keep fill counts, so no clearing
//  pass follows reset, row end or frame end.
// ----------------------------------------------------------------------------
module floyd_steinberg_palette_dither #(
  parameter int MAX_LINE_WIDTH = 4096,
  parameter int PALETTE_DEPTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [3:0]  entry_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  chosen_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        frame_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [12:0] image_width;
  logic [15:0] image_height;
  logic [4:0]  palette_count;
  logic        reg_wr;

  fspd_pkg::cmd_t    cmd;
  fspd_pkg::status_t status;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= fspd_pkg::IMAGE_WIDTH_RST;
      image_height  <= fspd_pkg::IMAGE_HEIGHT_RST;
      palette_count <= fspd_pkg::PALETTE_COUNT_RST;
    end else if (reg_wr) begin
      unique case (paddr[3:2])
        fspd_pkg::REG_IMAGE_WIDTH:   image_width   <= pwdata[12:0];
        fspd_pkg::REG_IMAGE_HEIGHT:  image_height  <= pwdata[15:0];
        fspd_pkg::REG_PALETTE_COUNT: palette_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      fspd_pkg::REG_IMAGE_WIDTH:   prdata = {19'd0, image_width};
      fspd_pkg::REG_IMAGE_HEIGHT:  prdata = {16'd0, image_height};
      fspd_pkg::REG_PALETTE_COUNT: prdata = {27'd0, palette_count};
      default:                     prdata = '0;
    endcase
  end

  fspd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .status   (status),
    .cmd      (cmd)
  );

  fspd_datapath #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
    .PALETTE_DEPTH  (PALETTE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .image_width   (image_width),
    .image_height  (image_height),
    .palette_count (palette_count),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .entry_slot    (entry_slot),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .chosen_index  (chosen_index),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .frame_end     (frame_end)
  );

endmodule
`default_nettype wire

### rtl/fspd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fspd_checker
// Port-level checks of the palette dither, bound to the top level.
// ----------------------------------------------------------------------------
module fspd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       func,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] chosen_index,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       frame_end,
  input logic       pready
);

  // no result survives reset
  a_rst_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chosen_index) &&
      $stable(out_red) && $stable(out_green) && $stable(out_blue) &&
      $stable(frame_end))
    else $error("stalled result changed");

  // a pixel transaction keeps the block busy in the next cycle
  a_pixel_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !func |=> !in_ready)
    else $error("input taken again right after a pixel");

  // a palette write never raises a result
  a_pal_no_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func && !out_valid |=> !out_valid)
    else $error("result after palette write");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind floyd_steinberg_palette_dither fspd_checker u_fspd_checker (.*);
`default_nettype wire

### bench/tb_floyd_steinberg_palette_dither.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_floyd_steinberg_palette_dither
// Self-checking bench for the palette dither. A local error-diffusion model
// predicts index, color and frame_end per pixel; random stalls on both sides,
// register changes between phases over small and extreme image sizes.
// ----------------------------------------------------------------------------
module tb_floyd_steinberg_palette_dither;

  localparam int LINE_MAX = 4096;
  localparam int PAL_MAX  = 16;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic       func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] entry_slot;
  } item_t;

  typedef struct packed {
    logic [3:0] index;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       fend;
  } pick_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, func = 0, out_ready = 0;
  logic [7:0] red = 0, green = 0, blue = 0;
  logic [3:0] entry_slot = 0;
  logic in_ready, out_valid, frame_end, pready;
  logic [3:0] chosen_index;
  logic [7:0] out_red, out_green, out_blue;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;

  always #10 clk = ~clk;

  floyd_steinberg_palette_dither uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .red(red), .green(green), .blue(blue), .entry_slot(entry_slot),
    .out_valid(out_valid), .out_ready(out_ready), .chosen_index(chosen_index),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .frame_end(frame_end), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // dither model state
  logic [12:0] cfg_width = fspd_pkg::IMAGE_WIDTH_RST;
  logic [15:0] cfg_height = fspd_pkg::IMAGE_HEIGHT_RST;
  logic [4:0]  cfg_count = fspd_pkg::PALETTE_COUNT_RST;
  logic [23:0] palette [PAL_MAX];
  int err_row [2][LINE_MAX][3];
  int bank_sel = 0;
  int col_pos = 0, row_pos = 0;

  item_t pending_items[$];
  pick_t expected_picks[$];
  int mismatches = 0, results_seen = 0, pixels_sent = 0, frames_seen = 0;
  bit stall_hold = 0, calm = 0;
  int hold_cycles = 0;
  int idle_cycles = 0;

  function automatic int floor_div16(int v);
    if (v >= 0) return v / 16;
    return -((-v + 15) / 16);
  endfunction

  function automatic int sat_err(int v);
    if (v > 4095) return 4095;
    if (v < -4096) return -4096;
    return v;
  endfunction

  function automatic int chan(logic [23:0] e, int c);
    return int'(e[16 - 8 * c +: 8]);
  endfunction

  task automatic dither_pixel(item_t it);
    int w, h, n, x, best, cur, nxt;
    int val[3], e[3];
    longint d, best_d;
    bit last_row, fend;
    pick_t p;
    if (it.func) begin
      palette[it.entry_slot] = {it.red, it.green, it.blue};
      return;
    end
    w = (cfg_width == 0) ? 1 : cfg_width;
    if (w > LINE_MAX) w = LINE_MAX;
    h = (cfg_height == 0) ? 1 : cfg_height;
    n = (cfg_count == 0) ? 1 : cfg_count;
    if (n > PAL_MAX) n = PAL_MAX;
    x = (col_pos >= w) ? w - 1 : col_pos;
    last_row = row_pos >= h - 1;
    cur = bank_sel;
    nxt = bank_sel ^ 1;
    val[0] = it.red * 16 + err_row[cur][x][0];
    val[1] = it.green * 16 + err_row[cur][x][1];
    val[2] = it.blue * 16 + err_row[cur][x][2];
    for (int c = 0; c < 3; c++) begin
      if (val[c] < 0) val[c] = 0;
      if (val[c] > 4080) val[c] = 4080;
    end
    best = 0;
    best_d = 0;
    for (int i = 0; i < n; i++) begin
      d = 0;
      for (int c = 0; c < 3; c++)
        d += longint'(val[c] - chan(palette[i], c) * 16) ** 2;
      if (i == 0 || d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    for (int c = 0; c < 3; c++) begin
      e[c] = val[c] - chan(palette[best], c) * 16;
      if (x + 1 < w)
        err_row[cur][x+1][c] = sat_err(err_row[cur][x+1][c] + floor_div16(e[c] * 7));
      if (!last_row) begin
        if (x > 0)
          err_row[nxt][x-1][c] = sat_err(err_row[nxt][x-1][c] + floor_div16(e[c] * 3));
        err_row[nxt][x][c] = sat_err(err_row[nxt][x][c] + floor_div16(e[c] * 5));
        if (x + 1 < w)
          err_row[nxt][x+1][c] = sat_err(err_row[nxt][x+1][c] + floor_div16(e[c]));
      end
    end
    fend = 0;
    if (x == w - 1) begin
      col_pos = 0;
      if (last_row) begin
        for (int b = 0; b < 2; b++)
          for (int j = 0; j < LINE_MAX; j++)
            for (int c = 0; c < 3; c++) err_row[b][j][c] = 0;
        row_pos = 0;
        fend = 1;
      end else begin
        for (int j = 0; j < LINE_MAX; j++)
          for (int c = 0; c < 3; c++) err_row[cur][j][c] = 0;
        bank_sel ^= 1;
        row_pos = (row_pos + 1) & 16'hFFFF;
      end
    end else begin
      col_pos = x + 1;
    end
    p.index = best[3:0];
    p.r = palette[best][23:16];
    p.g = palette[best][15:8];
    p.b = palette[best][7:0];
    p.fend = fend;
    expected_picks.insert(expected_picks.size(), p);
  endtask

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        dither_pixel(pending_items.pop_front());
        idle_cycles = 0;
        if (!func) pixels_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 9);
          in_valid <= 0;
        end else if (pending_items.size() > 0 &&
                     !(in_valid && in_ready && pending_items.size() == 0)) begin
          in_valid <= 1;
          func <= pending_items[0].func;
          red <= pending_items[0].red;
          green <= pending_items[0].green;
          blue <= pending_items[0].blue;
          entry_slot <= pending_items[0].entry_slot;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  int recv_gap = 0;
  always @(posedge clk) begin
    pick_t exp_p;
    if (!rst) begin
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        results_seen++;
        if (frame_end) frames_seen++;
        if (expected_picks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction idx=%0d", chosen_index);
        end else begin
          exp_p = expected_picks.pop_front();
          if (exp_p != {chosen_index, out_red, out_green, out_blue, frame_end}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp idx=%0d rgb=%h%h%h fe=%b, got idx=%0d rgb=%h%h%h fe=%b",
                exp_p.index, exp_p.r, exp_p.g, exp_p.b, exp_p.fend,
                chosen_index, out_red, out_green, out_blue, frame_end);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 0;
      end else if (stall_hold) begin
        out_ready <= 0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(1, 9);
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      idle_cycles++;
      if (idle_cycles > WATCHDOG) begin
        $display("watchdog expired, %0d still expected", expected_picks.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      fspd_pkg::REG_IMAGE_WIDTH:   cfg_width = value[12:0];
      fspd_pkg::REG_IMAGE_HEIGHT:  cfg_height = value[15:0];
      fspd_pkg::REG_PALETTE_COUNT: cfg_count = value[4:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_picks.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic item_t make_item(bit f, int r, int g, int b, int s);
    item_t it;
    it.func = f; it.red = r; it.green = g; it.blue = b; it.entry_slot = s;
    return it;
  endfunction

  task automatic load_palette(int count, bit extremes);
    for (int i = 0; i < count; i++)
      if (extremes)
        pending_items.insert(pending_items.size(),
                             make_item(1, (i & 1) ? 255 : 0, (i & 2) ? 255 : 0,
                                       (i & 4) ? 255 : 0, i));
      else
        pending_items.insert(pending_items.size(),
                             make_item(1, $urandom_range(0, 255), $urandom_range(0, 255),
                                       $urandom_range(0, 255), i));
  endtask

  task automatic push_pixels(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 29) == 0)
        pending_items.insert(pending_items.size(),
          make_item(1, $urandom, $urandom, $urandom,
                    $urandom_range(0, cfg_count > 0 ? cfg_count - 1 : 0)));
      else if ($urandom_range(0, 7) == 0)
        pending_items.insert(pending_items.size(),
          make_item(0, $urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                    $urandom_range(0, 1) * 255, $urandom));
      else
        pending_items.insert(pending_items.size(),
          make_item(0, $urandom, $urandom, $urandom, $urandom));
    end
  endtask

  initial begin
    int w, h, n;
    for (int i = 0; i < PAL_MAX; i++) palette[i] = 0;
    for (int b = 0; b < 2; b++)
      for (int j = 0; j < LINE_MAX; j++)
        for (int c = 0; c < 3; c++) err_row[b][j][c] = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: full palette incl. tie entries, tiny image, extreme pixels
    reg_write(fspd_pkg::REG_IMAGE_WIDTH, 3);
    reg_write(fspd_pkg::REG_IMAGE_HEIGHT, 2);
    reg_write(fspd_pkg::REG_PALETTE_COUNT, 16);
    load_palette(16, 1);
    pending_items.insert(pending_items.size(), make_item(0, 0, 0, 0, 15));
    pending_items.insert(pending_items.size(), make_item(0, 255, 255, 255, 0));
    pending_items.insert(pending_items.size(), make_item(0, 128, 127, 64, 9));
    pending_items.insert(pending_items.size(), make_item(0, 255, 0, 170, 0));
    pending_items.insert(pending_items.size(), make_item(0, 1, 254, 0, 0));
    pending_items.insert(pending_items.size(), make_item(0, 127, 128, 255, 0));
    drain();

    // single-entry palette, 1x1 image (each pixel ends a frame)
    reg_write(fspd_pkg::REG_IMAGE_WIDTH, 0);
    reg_write(fspd_pkg::REG_IMAGE_HEIGHT, 0);
    reg_write(fspd_pkg::REG_PALETTE_COUNT, 0);
    pending_items.insert(pending_items.size(), make_item(0, 200, 10, 99, 0));
    pending_items.insert(pending_items.size(), make_item(0, 255, 255, 255, 0));
    drain();

    // long receiver hold while the sender keeps offering
    reg_write(fspd_pkg::REG_IMAGE_WIDTH, 5);
    reg_write(fspd_pkg::REG_IMAGE_HEIGHT, 4);
    reg_write(fspd_pkg::REG_PALETTE_COUNT, 31);
    push_pixels(12);
    hold_cycles = 400;
    drain();

    // shrink width mid-frame: position past the new last column
    reg_write(fspd_pkg::REG_IMAGE_WIDTH, 2);
    push_pixels(9);
    drain();

    // random phases; the last runs without idling
    for (int ph = 0; ph < 12; ph++) begin
      w = (ph == 3) ? 8191 : (ph == 4 ? 4096 : $urandom_range(1, 12));
      h = (ph == 5) ? 65535 : $urandom_range(1, 6);
      n = (ph == 6) ? 1 : $urandom_range(2, 16);
      reg_write(fspd_pkg::REG_IMAGE_WIDTH, w);
      reg_write(fspd_pkg::REG_IMAGE_HEIGHT, h);
      reg_write(fspd_pkg::REG_PALETTE_COUNT, n);
      load_palette(16, 0);
      if (ph == 11) calm = 1;
      push_pixels(100);
      drain();
    end

    $display("covered %0d pixels, %0d results, %0d frame ends, sizes down to 1x1",
             pixels_sent, results_seen, frames_seen);
    if (mismatches == 0 && expected_picks.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

### files.f
rtl/fspd_pkg.sv
rtl/fspd_ctrl.sv
rtl/fspd_datapath.sv
rtl/floyd_steinberg_palette_dither.sv
rtl/fspd_checker.sv
bench/tb_floyd_steinberg_palette_dither.sv
